### sv/icmprv_pkg.sv
// ----------------------------------------------------------------------------
// ICMP reply validator package
// Shared constants, codes, the per-datagram state record and small helpers.
// ----------------------------------------------------------------------------
package icmprv_pkg;

  localparam int PAYLOAD_BYTES_DEF      = 32;
  localparam int MAX_DATAGRAM_BYTES_DEF = 2047;

  // Fixed ICMP header length in bytes.
  localparam int ICMP_HDR_BYTES = 8;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [7:0] TYPE_ECHO_REPLY    = 8'd0;
  localparam logic [7:0] TYPE_DEST_UNREACH  = 8'd3;
  localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;

  typedef enum logic [2:0] {
    STATUS_VALID,
    STATUS_BAD_TYPE,
    STATUS_BAD_ID,
    STATUS_BAD_CHECKSUM,
    STATUS_BAD_SEQUENCE,
    STATUS_TRUNCATED
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PROBE_ID,
    REG_TARGET_ADDR,
    REG_MAX_SEQ
  } cfg_reg_t;

  // Fields gathered while a datagram streams through.
  typedef struct packed {
    logic [3:0]  outer_words;
    logic [3:0]  inner_words;
    logic [7:0]  seen_type;
    logic [15:0] sum;
    logic [15:0] stored_checksum;
    logic [15:0] identifier;
    logic [15:0] sequence_num;
  } pkt_state_t;

  // Ones-complement 16-bit add with end-around carry.
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // Error messages that quote the offending datagram.
  function automatic logic is_quoting(input logic [7:0] t);
    return (t == TYPE_DEST_UNREACH) || (t == TYPE_TIME_EXCEEDED);
  endfunction

endpackage

### sv/icmprv_parse.sv
// ----------------------------------------------------------------------------
// ICMP reply validator byte parser
// Holds the per-datagram state and folds in one byte per step.
// ----------------------------------------------------------------------------
module icmprv_parse #(
  parameter int PAYLOAD_BYTES      = icmprv_pkg::PAYLOAD_BYTES_DEF,
  parameter int MAX_DATAGRAM_BYTES = icmprv_pkg::MAX_DATAGRAM_BYTES_DEF,
  localparam int PW   = $clog2(MAX_DATAGRAM_BYTES + 1),
  localparam int SPAN = icmprv_pkg::ICMP_HDR_BYTES + PAYLOAD_BYTES,
  localparam int KW   = $clog2(MAX_DATAGRAM_BYTES + SPAN + 64 + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  output icmprv_pkg::pkt_state_t snap,
  output logic [PW-1:0]          count,
  output logic [PW-1:0]          position
);

  localparam logic [KW-1:0] SPAN_K     = KW'(SPAN);
  localparam logic [KW-1:0] SPAN_LAST  = KW'(SPAN - 1);
  localparam logic [PW-1:0] MAX_K      = PW'(MAX_DATAGRAM_BYTES);
  localparam logic [KW-1:0] INNER_ID_K = KW'(icmprv_pkg::ICMP_HDR_BYTES + 4);

  icmprv_pkg::pkt_state_t st, st_next;
  logic [7:0]             pending_high_byte, pending_high_byte_next;
  logic [PW-1:0]          position_next;

  always_comb begin
    logic [KW-1:0] off;
    logic [KW-1:0] pos_k;
    logic [KW-1:0] r;
    logic [KW-1:0] id_hi;
    logic [7:0]    v;
    st_next                = st;
    pending_high_byte_next = pending_high_byte;
    position_next          = position;
    off                    = '0;
    pos_k                  = KW'(position);
    r                      = '0;
    id_hi                  = KW'({st.inner_words, 2'b00}) + INNER_ID_K;
    v                      = data_byte;
    if (position < MAX_K) begin
      if (position == '0) begin
        st_next.outer_words = data_byte[3:0];
      end
      off = KW'({st_next.outer_words, 2'b00});
      if (pos_k >= off) begin
        r = pos_k - off;
        if (r == KW'(0)) st_next.seen_type = data_byte;
        if (r == KW'(2)) st_next.stored_checksum[15:8] = data_byte;
        if (r == KW'(3)) st_next.stored_checksum[7:0] = data_byte;
        if (r == KW'(6)) st_next.sequence_num[15:8] = data_byte;
        if (r == KW'(7)) st_next.sequence_num[7:0] = data_byte;
        if (r == KW'(8)) st_next.inner_words = data_byte[3:0];
        if (st_next.seen_type == icmprv_pkg::TYPE_ECHO_REPLY) begin
          if (r == KW'(4)) st_next.identifier[15:8] = data_byte;
          if (r == KW'(5)) st_next.identifier[7:0] = data_byte;
        end
        // The quoted identifier sits after the inner IP header.
        if (icmprv_pkg::is_quoting(st_next.seen_type)) begin
          if (r == id_hi) st_next.identifier[15:8] = data_byte;
          if (r == id_hi + KW'(1)) st_next.identifier[7:0] = data_byte;
        end
        if (r < SPAN_K) begin
          if (r == KW'(2) || r == KW'(3)) v = 8'h00;
          if (!r[0]) begin
            if (r == SPAN_LAST) begin
              st_next.sum = icmprv_pkg::ones_add(st.sum, {v, 8'h00});
            end else begin
              pending_high_byte_next = v;
            end
          end else begin
            st_next.sum = icmprv_pkg::ones_add(st.sum, {pending_high_byte, v});
          end
        end
      end
      position_next = position + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st                <= '0;
      pending_high_byte <= '0;
      position          <= '0;
    end else if (step) begin
      if (last_byte) begin
        st                <= '0;
        pending_high_byte <= '0;
        position          <= '0;
      end else begin
        st                <= st_next;
        pending_high_byte <= pending_high_byte_next;
        position          <= position_next;
      end
    end
  end

  assign snap  = st_next;
  assign count = position_next;

endmodule

### sv/icmprv_check.sv
// ----------------------------------------------------------------------------
// ICMP reply validator verdict logic
// Turns the final datagram state into a status, a type and a target flag.
// ----------------------------------------------------------------------------
module icmprv_check #(
  parameter int PAYLOAD_BYTES      = icmprv_pkg::PAYLOAD_BYTES_DEF,
  parameter int MAX_DATAGRAM_BYTES = icmprv_pkg::MAX_DATAGRAM_BYTES_DEF,
  localparam int PW   = $clog2(MAX_DATAGRAM_BYTES + 1),
  localparam int SPAN = icmprv_pkg::ICMP_HDR_BYTES + PAYLOAD_BYTES,
  localparam int KW   = $clog2(MAX_DATAGRAM_BYTES + SPAN + 64 + 1)
) (
  input  icmprv_pkg::pkt_state_t snap,
  input  logic [PW-1:0]          count,
  input  logic [15:0]            probe_identifier,
  input  logic [31:0]            target_address,
  input  logic [15:0]            max_sequence,
  input  logic [31:0]            sender_address,
  output icmprv_pkg::status_t    status,
  output logic                   dest_hit,
  output logic [7:0]             message_type
);

  localparam logic [KW-1:0] SPAN_K    = KW'(SPAN);
  localparam logic [KW-1:0] ECHO_ID_K = KW'(6);
  localparam logic [KW-1:0] QUOTE_ID_K = KW'(icmprv_pkg::ICMP_HDR_BYTES + 6);

  logic [KW-1:0] off, cnt, need, idend;

  always_comb begin
    off   = KW'({snap.outer_words, 2'b00});
    cnt   = KW'(count);
    need  = off + SPAN_K;
    if (snap.seen_type == icmprv_pkg::TYPE_ECHO_REPLY) begin
      idend = off + ECHO_ID_K;
    end else begin
      idend = off + KW'({snap.inner_words, 2'b00}) + QUOTE_ID_K;
    end
    if (idend > need) need = idend;

    message_type = snap.seen_type;
    if (cnt <= off) begin
      status       = icmprv_pkg::STATUS_TRUNCATED;
      message_type = icmprv_pkg::TYPE_ECHO_REPLY;
    end else if (snap.seen_type != icmprv_pkg::TYPE_ECHO_REPLY &&
                 !icmprv_pkg::is_quoting(snap.seen_type)) begin
      status = icmprv_pkg::STATUS_BAD_TYPE;
    end else if (cnt < need) begin
      status = icmprv_pkg::STATUS_TRUNCATED;
    end else if (snap.identifier != probe_identifier) begin
      status = icmprv_pkg::STATUS_BAD_ID;
    end else if (~snap.sum != snap.stored_checksum) begin
      status = icmprv_pkg::STATUS_BAD_CHECKSUM;
    end else if (snap.sequence_num > max_sequence) begin
      status = icmprv_pkg::STATUS_BAD_SEQUENCE;
    end else begin
      status = icmprv_pkg::STATUS_VALID;
    end
    dest_hit = (status == icmprv_pkg::STATUS_VALID) &&
               (message_type == icmprv_pkg::TYPE_ECHO_REPLY) &&
               (sender_address == target_address);
  end

endmodule

### sv/icmp_reply_validator_core.sv
// ----------------------------------------------------------------------------
// ICMP reply validator core
// Streams a received IPv4 datagram and reports one verdict per datagram.
// ----------------------------------------------------------------------------
// The block takes one datagram byte per cycle with no gaps of its own: every
// byte passes an input register, then the update logic that folds it into
// the datagram state (offsets, checksum, identifier, sequence). The byte
// marked by tlast also produces a verdict, which is registered in the result
// register and held there until it is taken. Input is stalled only while a
// finished verdict waits and another last byte arrives. Bytes beyond
// MAX_DATAGRAM_BYTES are ignored. The user must write registers through
// the cfg port while no datagram is in flight; the block does not enforce it.
module icmp_reply_validator_core #(
  parameter int PAYLOAD_BYTES      = icmprv_pkg::PAYLOAD_BYTES_DEF,
  parameter int MAX_DATAGRAM_BYTES = icmprv_pkg::MAX_DATAGRAM_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [39:0]                        s_axis_tdata,  // data_byte, sender_address
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [15:0]                        m_axis_tdata,  // status, dest_hit,
                                                            // message_type, zero pad
  input  logic                               cfg_we,
  input  logic [icmprv_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [icmprv_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int PW = $clog2(MAX_DATAGRAM_BYTES + 1);

  logic [15:0] probe_identifier;
  logic [31:0] target_address;
  logic [15:0] max_sequence;

  logic        s1_valid;
  logic [7:0]  s1_data;
  logic        s1_last;
  logic [31:0] s1_sender;
  logic        advance;

  icmprv_pkg::pkt_state_t snap;
  logic [PW-1:0]          count;
  logic [PW-1:0]          position;
  icmprv_pkg::status_t    status;
  logic                   dest_hit;
  logic [7:0]             message_type;

  logic                   out_valid;
  icmprv_pkg::status_t    out_status;
  logic                   out_reached;
  logic [7:0]             out_type;

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_identifier <= '0;
      target_address   <= '0;
      max_sequence     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        icmprv_pkg::REG_PROBE_ID:    probe_identifier <= cfg_data[15:0];
        icmprv_pkg::REG_TARGET_ADDR: target_address   <= cfg_data[31:0];
        icmprv_pkg::REG_MAX_SEQ:     max_sequence     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // A byte moves on unless it would produce a verdict while one still waits.
  assign advance       = s1_valid && (!s1_last || !out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_data   <= s_axis_tdata[7:0];
      s1_sender <= s_axis_tdata[39:8];
      s1_last   <= s_axis_tlast;
    end
  end

  icmprv_parse #(
    .PAYLOAD_BYTES      (PAYLOAD_BYTES),
    .MAX_DATAGRAM_BYTES (MAX_DATAGRAM_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (s1_data),
    .last_byte (s1_last),
    .snap      (snap),
    .count     (count),
    .position  (position)
  );

  icmprv_check #(
    .PAYLOAD_BYTES      (PAYLOAD_BYTES),
    .MAX_DATAGRAM_BYTES (MAX_DATAGRAM_BYTES)
  ) u_check (
    .snap             (snap),
    .count            (count),
    .probe_identifier (probe_identifier),
    .target_address   (target_address),
    .max_sequence     (max_sequence),
    .sender_address   (s1_sender),
    .status           (status),
    .dest_hit         (dest_hit),
    .message_type     (message_type)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_last) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last) begin
      out_status  <= status;
      out_reached <= dest_hit;
      out_type    <= message_type;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_type, out_reached, out_status};

  // A last byte that moves on always leaves a verdict behind.
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_last) |=> out_valid)
    else $error("last byte processed without a verdict");

  // The datagram state restarts after every last byte.
  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_last) |=> (position == '0))
    else $error("byte position not cleared after datagram end");

  // A target hit is only ever reported on a valid echo reply.
  a_reached_valid_echo: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_reached) |->
      (out_status == icmprv_pkg::STATUS_VALID &&
       out_type == icmprv_pkg::TYPE_ECHO_REPLY))
    else $error("target reached on a non-valid or non-echo verdict");

  // A waiting verdict is never overwritten by the next datagram.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_axis_tready) |-> !(advance && s1_last))
    else $error("verdict overwritten while waiting");

endmodule
